// File: hw/rtl/table_driven_wildcard_dfa_matcher_unit_assert.svh
// Assertion macros used by the matcher RTL
`ifndef TABLE_DRIVEN_WILDCARD_DFA_MATCHER_UNIT_ASSERT_SVH
`define TABLE_DRIVEN_WILDCARD_DFA_MATCHER_UNIT_ASSERT_SVH

// same-cycle implication
`define TDW_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TDW_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/tdwdfa_pkg.sv
// Types, constants and helpers for the wildcard DFA matcher
package tdwdfa_pkg;

   localparam int TABLE_DEPTH = 1024;
   localparam int TABLE_AW    = $clog2(TABLE_DEPTH);
   localparam int WORD_W      = 16;
   localparam int CHAR_W      = 16;
   localparam int CMD_W       = 2;
   localparam int WADDR_W     = 10;
   // pair offset reaches the span rounded up to even
   localparam int SPAN_W      = WORD_W + 1;
   // widest scan address: index + 3 + offset
   localparam int SCAN_W      = ((TABLE_AW > SPAN_W) ? TABLE_AW : SPAN_W) + 1;

   localparam logic [31:0]         DEPTH_U32   = 32'(TABLE_DEPTH);
   localparam logic [TABLE_AW-1:0] START_INDEX = TABLE_AW'(1);

   localparam logic [CMD_W-1:0] CMD_WRITE  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_FEED   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_FINISH = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SPAN,
      ST_LABEL,
      ST_NEXT,
      ST_FIN,
      ST_HOLD
   } state_type;

   function automatic logic scan_in_table(input logic [SCAN_W-1:0] addr);
      return addr < SCAN_W'(TABLE_DEPTH);
   endfunction

endpackage

// File: hw/rtl/tdwdfa_ram.sv
// Generic single-port-write, registered-read RAM
module tdwdfa_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/table_driven_wildcard_dfa_matcher_unit.sv
// Top level of the table-driven wildcard DFA matcher
//
//   channel | ports                                        | direction
//   --------+----------------------------------------------+----------
//   req     | req_valid req_stall req_cmd req_word_addr    | in
//           | req_word_data req_char_code                  |
//   rsp     | rsp_valid rsp_stall rsp_matched rsp_table_fault | out
//
// A table write is taken in the idle state. A character passes the span state,
// the label state once per label compared before a match or the default arrow,
// and the next state; the single table read port gives one word per cycle. A finish
// reads the final word in the fin state and loads the result, or waits in hold.
// Reset (synchronous) sets the index to one and clears the fault flag; the table
// keeps no reset. A stalled result is held in the output register while the next
// beat is taken; a second finish waits until that register frees.
`include "table_driven_wildcard_dfa_matcher_unit_assert.svh"

module table_driven_wildcard_dfa_matcher_unit
   import tdwdfa_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [CMD_W-1:0]   req_cmd,
   input  logic [WADDR_W-1:0] req_word_addr,
   input  logic [WORD_W-1:0]  req_word_data,
   input  logic [CHAR_W-1:0]  req_char_code,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_matched,
   output logic               rsp_table_fault
);

   state_type             state_ff, state_in;
   logic [TABLE_AW-1:0]   cur_ff, cur_in;
   logic                  fault_ff, fault_in;
   logic [CHAR_W-1:0]     char_ff, char_in;
   logic [WORD_W-1:0]     span_ff, span_in;
   logic [SPAN_W-1:0]     j_ff, j_in;
   logic                  rd_oob_ff, rd_oob_in;
   logic                  fin_ff, fin_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_matched_ff, rsp_matched_in;
   logic                  rsp_fault_ff, rsp_fault_in;

   logic                  req_acc;
   logic                  out_free;
   logic                  rsp_load;
   logic [WORD_W-1:0]     ram_rdata;
   logic [WORD_W-1:0]     rd_word;
   logic [SCAN_W-1:0]     rd_addr_full;
   logic                  ram_we;
   logic [SPAN_W-1:0]     j_next;
   logic                  label_hit;
   logic                  label_more;

   tdwdfa_ram #(
      .WIDTH (WORD_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (TABLE_AW'(req_word_addr)),
      .wr_data (req_word_data),
      .rd_addr (rd_addr_full[TABLE_AW-1:0]),
      .rd_data (ram_rdata)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign req_acc   = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_load  = ((state_ff == ST_FIN) || (state_ff == ST_HOLD)) && out_free;
   assign ram_we    = req_acc && (req_cmd == CMD_WRITE) && (32'(req_word_addr) < DEPTH_U32);

   // reads past the table answer zero
   assign rd_word    = rd_oob_ff ? '0 : ram_rdata;
   assign j_next     = j_ff + SPAN_W'(2);
   assign label_hit  = (rd_word == char_ff);
   assign label_more = !label_hit && (j_next < SPAN_W'(span_ff));
   assign rd_oob_in  = !scan_in_table(rd_addr_full);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               case (req_cmd)
                  CMD_FEED:   state_in = ST_SPAN;
                  CMD_FINISH: state_in = ST_FIN;
                  default:    state_in = ST_IDLE;
               endcase
            end
         end
         ST_SPAN:  state_in = (rd_word != '0) ? ST_LABEL : ST_NEXT;
         ST_LABEL: state_in = label_more ? ST_LABEL : ST_NEXT;
         ST_NEXT:  state_in = ST_IDLE;
         ST_FIN:   state_in = out_free ? ST_IDLE : ST_HOLD;
         ST_HOLD:  state_in = out_free ? ST_IDLE : ST_HOLD;
         default:  state_in = ST_IDLE;
      endcase
   end

   // datapath and read address
   always_comb begin
      cur_in         = cur_ff;
      fault_in       = fault_ff;
      char_in        = char_ff;
      span_in        = span_ff;
      j_in           = j_ff;
      fin_in         = fin_ff;
      rd_addr_full   = SCAN_W'(cur_ff);
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_matched_in = rsp_matched_ff;
      rsp_fault_in   = rsp_fault_ff;
      case (state_ff)
         ST_IDLE: begin
            char_in = req_char_code;
            if (req_cmd == CMD_FEED) begin
               rd_addr_full = SCAN_W'(cur_ff) + SCAN_W'(1);
            end
         end
         ST_SPAN: begin
            span_in  = rd_word;
            j_in     = '0;
            fault_in = fault_ff | rd_oob_ff;
            rd_addr_full = SCAN_W'(cur_ff) + ((rd_word != '0) ? SCAN_W'(2) : SCAN_W'(3));
         end
         ST_LABEL: begin
            fault_in = fault_ff | rd_oob_ff;
            j_in     = label_hit ? j_ff : j_next;
            rd_addr_full = SCAN_W'(cur_ff) + SCAN_W'(label_hit ? j_ff : j_next)
                         + (label_more ? SCAN_W'(2) : SCAN_W'(3));
         end
         ST_NEXT: begin
            // keep the index when the jump leaves the table
            if (rd_oob_ff || !(32'(rd_word) < DEPTH_U32)) begin
               fault_in = 1'b1;
            end
            if (32'(rd_word) < DEPTH_U32) begin
               cur_in = TABLE_AW'(rd_word);
            end
         end
         ST_FIN: begin
            fin_in = (rd_word != '0);
         end
         default: begin
         end
      endcase
      if (rsp_load) begin
         rsp_valid_in   = 1'b1;
         rsp_matched_in = (state_ff == ST_FIN) ? (rd_word != '0) : fin_ff;
         rsp_fault_in   = fault_ff;
         cur_in         = START_INDEX;
         fault_in       = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cur_ff       <= START_INDEX;
         fault_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_ff       <= cur_in;
         fault_ff     <= fault_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      char_ff        <= char_in;
      span_ff        <= span_in;
      j_ff           <= j_in;
      rd_oob_ff      <= rd_oob_in;
      fin_ff         <= fin_in;
      rsp_matched_ff <= rsp_matched_in;
      rsp_fault_ff   <= rsp_fault_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_matched     = rsp_matched_ff;
   assign rsp_table_fault = rsp_fault_ff;

   `TDW_ASSERT_NEXT(a_feed_starts_scan, clock, reset,
      req_acc && (req_cmd == CMD_FEED), state_ff == ST_SPAN,
      "feed beat did not start the span read")
   `TDW_ASSERT_IMPL(a_rsp_from_finish, clock, reset,
      $rose(rsp_valid_ff), $past(state_ff == ST_FIN) || $past(state_ff == ST_HOLD),
      "result raised without a finish")
   `TDW_ASSERT_NEXT(a_finish_restarts, clock, reset,
      rsp_load, (cur_ff == START_INDEX) && !fault_ff,
      "finish did not restart the automaton")
   `TDW_ASSERT_IMPL(a_label_in_span, clock, reset,
      state_ff == ST_LABEL, j_ff < SPAN_W'(span_ff),
      "label scan ran past the arrow span")

endmodule

// File: sim/dfa_report_checker.sv
// Checker for the wildcard DFA matcher: predicts each finish report and compares it
`timescale 1ns / 1ps
module dfa_report_checker
   import tdwdfa_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic [CMD_W-1:0]   req_cmd,
   input  logic [WADDR_W-1:0] req_word_addr,
   input  logic [WORD_W-1:0]  req_word_data,
   input  logic [CHAR_W-1:0]  req_char_code,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic               rsp_matched,
   input  logic               rsp_table_fault,
   output int                 mismatch_count,
   output int                 reports_pending
);

   localparam int MAX_SHOWN = 10;

   typedef struct packed {
      logic matched;
      logic table_fault;
   } match_report_type;

   logic [WORD_W-1:0] table_copy [TABLE_DEPTH];
   int unsigned       state_index;
   logic              lookup_fault;
   match_report_type  report_q [$];
   match_report_type  next_report;
   match_report_type  oldest;

   // out-of-table reads raise the fault and answer zero
   function automatic logic [WORD_W-1:0] fetch_word(input int unsigned addr);
      if (addr >= TABLE_DEPTH) begin
         lookup_fault = 1'b1;
         return '0;
      end
      return table_copy[addr];
   endfunction

   task automatic advance_on_char(input logic [CHAR_W-1:0] ch);
      int unsigned span;
      int unsigned offset;
      int unsigned dest;
      logic        hit;
      span   = fetch_word(state_index + 1);
      offset = 0;
      hit    = 1'b0;
      // first matching label wins; past the span the pair is the default arrow
      while (!hit && offset < span) begin
         if (fetch_word(state_index + 2 + offset) == ch)
            hit = 1'b1;
         else
            offset += 2;
      end
      dest = fetch_word(state_index + 3 + offset);
      if (dest >= TABLE_DEPTH)
         lookup_fault = 1'b1;
      else
         state_index = dest;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         state_index  = START_INDEX;
         lookup_fault = 1'b0;
         report_q.delete();
         mismatch_count <= 0;
      end else begin
         // results first: a report leaving now never belongs to a finish taken now
         if (rsp_valid && !rsp_stall) begin
            if (report_q.size() == 0) begin
               if (mismatch_count < MAX_SHOWN)
                  $display("%0t: report beat with none predicted (matched %b, table_fault %b)",
                           $realtime, rsp_matched, rsp_table_fault);
               mismatch_count <= mismatch_count + 1;
            end else begin
               oldest = report_q.pop_front();
               if (rsp_matched !== oldest.matched ||
                   rsp_table_fault !== oldest.table_fault) begin
                  if (mismatch_count < MAX_SHOWN)
                     $display("%0t: mismatch: matched exp %b got %b, fault exp %b got %b",
                              $realtime, oldest.matched, rsp_matched,
                              oldest.table_fault, rsp_table_fault);
                  mismatch_count <= mismatch_count + 1;
               end
            end
         end
         if (req_valid && !req_stall) begin
            case (req_cmd)
               CMD_WRITE: begin
                  table_copy[req_word_addr] = req_word_data;
               end
               CMD_FEED: begin
                  advance_on_char(req_char_code);
               end
               CMD_FINISH: begin
                  next_report.matched     = (fetch_word(state_index) != '0);
                  next_report.table_fault = lookup_fault;
                  report_q.push_back(next_report);
                  state_index  = START_INDEX;
                  lookup_fault = 1'b0;
               end
               default: ;  // drop the unused command
            endcase
         end
      end
      reports_pending <= report_q.size();
   end

endmodule

// File: sim/table_driven_wildcard_dfa_matcher_unit_tb.sv
// Testbench top for the wildcard DFA matcher: table loading, strings and the verdict
`timescale 1ns / 1ps
module table_driven_wildcard_dfa_matcher_unit_tb
   import tdwdfa_pkg::*;
();

   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam int RANDOM_ITEMS   = 400;
   localparam int STALL_PCT      = 7;
   localparam int WATCHDOG_LIMIT = 200000;
   localparam int DRAIN_CYCLES   = 20;
   localparam int LABEL_SET      = 6;
   localparam int LAYOUT_END     = 1016;  // records stay below, the rest is scratch
   localparam int SCRATCH_REC    = 1020;
   localparam int QUIET_FROM     = 100;
   localparam int QUIET_TO       = 250;
   localparam int PAUSE_AT       = 300;

   typedef enum logic [2:0] {
      ROLE_FILL,
      ROLE_FINAL,
      ROLE_SPAN,
      ROLE_LABEL,
      ROLE_NEXT
   } word_role_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [CMD_W-1:0]   req_cmd = CMD_WRITE;
   logic [WADDR_W-1:0] req_word_addr = '0;
   logic [WORD_W-1:0]  req_word_data = '0;
   logic [CHAR_W-1:0]  req_char_code = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic               rsp_matched;
   logic               rsp_table_fault;
   int                 mismatch_count;
   int                 reports_pending;
   logic               quiet = 1'b0;
   int                 idle_cycles = 0;

   logic [WORD_W-1:0]  table_img [TABLE_DEPTH];
   word_role_type      word_role [TABLE_DEPTH];
   int unsigned        record_start [$];

   table_driven_wildcard_dfa_matcher_unit i_dut (.*);
   dfa_report_checker i_checker (.*);

   initial begin
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_stall <= !reset && !quiet && ($urandom_range(99) < STALL_PCT);
   end

   // end the run when nothing moves on either channel for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_beat(input logic [CMD_W-1:0] cmd, input logic [WADDR_W-1:0] addr,
                            input logic [WORD_W-1:0] data, input logic [CHAR_W-1:0] ch);
      if (!quiet && $urandom_range(99) < STALL_PCT) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(3, 1)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_cmd       <= cmd;
      req_word_addr <= addr;
      req_word_data <= data;
      req_char_code <= ch;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic write_word(input int unsigned addr, input logic [WORD_W-1:0] data);
      table_img[addr] = data;
      send_beat(CMD_WRITE, WADDR_W'(addr), data, CHAR_W'($urandom));
   endtask

   task automatic feed_char(input logic [CHAR_W-1:0] ch);
      send_beat(CMD_FEED, WADDR_W'($urandom), WORD_W'($urandom), ch);
   endtask

   task automatic end_string();
      send_beat(CMD_FINISH, WADDR_W'($urandom), WORD_W'($urandom), CHAR_W'($urandom));
   endtask

   // hold the sender until every predicted report has come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (reports_pending != 0) @(posedge clock);
   endtask

   function automatic logic [WORD_W-1:0] pick_word(input word_role_type role);
      logic [WORD_W-1:0] value;
      int                pick;
      pick = $urandom_range(99);
      case (role)
         ROLE_FINAL: begin
            value = (pick < 10) ? 16'h8000 :
                    (pick < 15) ? WORD_W'($urandom) : WORD_W'($urandom_range(1));
         end
         ROLE_SPAN: begin
            value = (pick < 80) ? WORD_W'(2 * $urandom_range(3)) :
                    (pick < 95) ? WORD_W'(2 * $urandom_range(3) + 1) :
                                  WORD_W'($urandom_range(30));
         end
         ROLE_LABEL: begin
            value = (pick < 93) ? WORD_W'($urandom_range(LABEL_SET - 1)) : WORD_W'($urandom);
         end
         ROLE_NEXT: begin
            value = (pick < 85) ?
                       WORD_W'(record_start[$urandom_range(record_start.size() - 1)]) :
                    (pick < 90) ? WORD_W'($urandom_range(TABLE_DEPTH - 1)) :
                                  WORD_W'($urandom_range(16'hFFFF, TABLE_DEPTH));
         end
         default: begin
            value = WORD_W'($urandom_range(1));
         end
      endcase
      return value;
   endfunction

   initial begin
      int unsigned       addr;
      int                arrows;
      int                items;
      int                len;
      int                roll;
      logic              paused;
      logic [WORD_W-1:0] saved_span;
      logic [WORD_W-1:0] saved_next;
      logic [CHAR_W-1:0] ch;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // lay out state records from index 1; spans follow the arrow count
      word_role[0] = ROLE_FILL;
      addr   = 1;
      arrows = $urandom_range(4, 1);
      while (addr + 2 + 2 * arrows <= LAYOUT_END) begin
         record_start.push_back(addr);
         word_role[addr]     = ROLE_FINAL;
         word_role[addr + 1] = ROLE_SPAN;
         table_img[addr + 1] = WORD_W'(2 * arrows - 2);
         for (int p = 0; p < arrows; p++) begin
            word_role[addr + 2 + 2 * p] = ROLE_LABEL;
            word_role[addr + 3 + 2 * p] = ROLE_NEXT;
         end
         addr  += 2 + 2 * arrows;
         arrows = $urandom_range(4, 1);
      end
      for (; addr < TABLE_DEPTH; addr++) word_role[addr] = ROLE_FILL;
      for (int a = 0; a < TABLE_DEPTH; a++)
         write_word(a, (word_role[a] == ROLE_SPAN) ? table_img[a] : pick_word(word_role[a]));

      // directed: extremes, the unused command, jumps and reads past the table
      end_string();
      feed_char(16'hFFFF);
      send_beat(CMD_UNUSED, '1, '1, '1);
      feed_char(16'h0000);
      end_string();
      saved_span = table_img[2];
      saved_next = table_img[4];
      write_word(2, 16'h0000);  // start record keeps only its default arrow
      write_word(4, 16'hFFFF);
      feed_char(CHAR_W'($urandom));
      end_string();
      write_word(4, WORD_W'(SCRATCH_REC));
      write_word(SCRATCH_REC, 16'h0001);
      write_word(SCRATCH_REC + 1, 16'h0004);
      write_word(SCRATCH_REC + 2, 16'h0007);
      write_word(SCRATCH_REC + 3, WORD_W'(SCRATCH_REC));
      feed_char(CHAR_W'($urandom));
      feed_char(16'h0007);
      feed_char(16'h0000);
      end_string();
      write_word(SCRATCH_REC + 3, WORD_W'(TABLE_DEPTH - 1));
      feed_char(CHAR_W'($urandom));
      feed_char(16'h0007);
      feed_char(CHAR_W'($urandom));
      end_string();
      write_word(SCRATCH_REC + 1, 16'hFFFF);
      feed_char(CHAR_W'($urandom));
      feed_char(16'hABCD);
      end_string();
      write_word(2, saved_span);
      write_word(4, saved_next);
      for (int a = SCRATCH_REC; a < TABLE_DEPTH; a++) write_word(a, pick_word(ROLE_FILL));
      wait_drained();

      // random strings over the table, with table rewrites and unused commands mixed in
      items  = 0;
      paused = 1'b0;
      while (items < RANDOM_ITEMS) begin
         quiet <= (items >= QUIET_FROM && items < QUIET_TO);
         if (!paused && items >= PAUSE_AT) begin
            wait_drained();
            paused = 1'b1;
         end
         len = $urandom_range(8);
         for (int n = 0; n < len; n++) begin
            roll = $urandom_range(99);
            if (roll < 8) begin
               addr = $urandom_range(TABLE_DEPTH - 1);
               write_word(addr, pick_word(word_role[addr]));
               items++;
            end else if (roll < 11) begin
               send_beat(CMD_UNUSED, WADDR_W'($urandom), WORD_W'($urandom),
                         CHAR_W'($urandom));
            end else begin
               roll = $urandom_range(99);
               ch = (roll < 85) ? CHAR_W'($urandom_range(LABEL_SET - 1)) :
                    (roll < 97) ? CHAR_W'($urandom) : 16'hFFFF;
               feed_char(ch);
               items++;
            end
         end
         // now and then leave a string open so the next one runs on from it
         if (len == 0 || $urandom_range(9) != 0) begin
            end_string();
            items++;
         end
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/tdwdfa_pkg.sv
hw/rtl/tdwdfa_ram.sv
hw/rtl/table_driven_wildcard_dfa_matcher_unit.sv
sim/dfa_report_checker.sv
sim/table_driven_wildcard_dfa_matcher_unit_tb.sv
